### rtl/txtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_pkg: shared types and constants of the text console writer
// Holds the item and result word layouts, the controller state encoding,
// the command and status groups between controller and datapath, and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package txtc_pkg;

  // Fixed field widths of the item and result words.
  localparam int CHAR_W      = 8;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int COLOR_W     = 4;
  localparam int CELL_W      = 16;

  // Item commands.
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACK = 1'd1;
  localparam logic [COLOR_W-1:0] FORE_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;

  // Input item word.
  typedef struct packed {
    logic                   command;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_column;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [CELL_W-1:0]      cell_value;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic                   scrolled;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic put_en;
    logic read_en;
    logic read_load;
    logic scroll_start;
    logic scroll_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic scroll_last;
    logic put_scrolls;
    logic item_is_read;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

### rtl/txtc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module txtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/txtc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_datapath: cursor, colors, screen store and result register
// Executes the controller's commands: clearing sweep, cell writes at the
// cursor, cell reads, the row copy of a scroll, and loading of the result
// word. Reports sweep ends and handshake state back to the controller.
// ----------------------------------------------------------------------------
module txtc_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire txtc_pkg::cmd_t                      cmd,
  output txtc_pkg::stat_t                          stat,
  input  wire txtc_pkg::item_t                     item,
  input  wire logic                                result_stall,
  output logic                                     result_valid,
  output txtc_pkg::result_t                        result,
  input  wire logic                                cfg_valid,
  input  wire logic [txtc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [txtc_pkg::COLOR_W-1:0]        cfg_data
);

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int AW        = $clog2(CELLS);
  localparam int SW        = AW + 1;
  localparam int RW        = $clog2(ROWS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RFW       = txtc_pkg::ROW_FIELD_W;
  localparam int CFW       = txtc_pkg::COL_FIELD_W;
  localparam int CLW       = txtc_pkg::COLOR_W;
  localparam int CEW       = txtc_pkg::CELL_W;
  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);

  // Architectural state.
  logic [RW-1:0]  cur_row;
  logic [CW-1:0]  cur_col;
  logic [AW-1:0]  cur_addr;
  logic [CLW-1:0] fore;
  logic [CLW-1:0] back;

  // Sweep counters.
  logic [AW-1:0]  clear_addr;
  logic [SW-1:0]  scroll_addr;
  logic [AW-1:0]  scroll_wr_addr;
  logic           scroll_wr_pend;
  logic           rd_in_range;

  // RAM port signals.
  logic           ram_we;
  logic [AW-1:0]  ram_wa;
  logic [CEW-1:0] ram_wd;
  logic           ram_re;
  logic [AW-1:0]  ram_ra;
  logic [CEW-1:0] ram_rd;

  // Put and read helpers.
  logic [CEW-1:0] put_cell;
  logic           col_last;
  logic           row_last;
  logic [RW-1:0]  row_next;
  logic [CW-1:0]  col_next;
  logic [AW-1:0]  addr_next;
  logic           scroll_reading;
  logic           read_ok;
  logic [AW-1:0]  read_addr;

  // Cell built from the current colors and the item's character.
  assign put_cell = {back, fore, item.char_code};

  // Cursor advance with line wrap and scroll.
  assign col_last = (cur_col == CW'(COLUMNS - 1));
  assign row_last = (cur_row == RW'(ROWS - 1));

  always_comb begin
    row_next  = cur_row;
    col_next  = cur_col + CW'(1);
    addr_next = cur_addr + AW'(1);
    if (col_last) begin
      col_next = '0;
      if (row_last) begin
        addr_next = LAST_BASE;
      end else begin
        row_next = cur_row + RW'(1);
      end
    end
  end

  // Read address and range check of a read item.
  assign read_ok   = (32'(item.read_row) < ROWS) && (32'(item.read_column) < COLUMNS);
  assign read_addr = AW'(item.read_row) * AW'(COLUMNS) + AW'(item.read_column);

  assign scroll_reading = (scroll_addr < SW'(CELLS));

  // RAM port selection.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = cur_addr;
    ram_wd = put_cell;
    if (cmd.clear_en) begin
      ram_we = 1'b1;
      ram_wa = clear_addr;
      ram_wd = '0;
    end else if (cmd.put_en) begin
      ram_we = 1'b1;
    end else if (cmd.scroll_en && scroll_wr_pend) begin
      ram_we = 1'b1;
      ram_wa = scroll_wr_addr;
      ram_wd = ram_rd;
    end
  end

  assign ram_re = cmd.read_en || (cmd.scroll_en && scroll_reading);
  assign ram_ra = cmd.scroll_en ? scroll_addr[AW-1:0] : read_addr;

  txtc_ram #(
    .WIDTH (CEW),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      cur_addr <= '0;
    end else if (cmd.put_en) begin
      cur_row  <= row_next;
      cur_col  <= col_next;
      cur_addr <= addr_next;
    end
  end

  // Color registers, written through the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      fore <= txtc_pkg::FORE_RESET;
      back <= txtc_pkg::BACK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        txtc_pkg::CFG_FORE: fore <= cfg_data;
        txtc_pkg::CFG_BACK: back <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_en) begin
      clear_addr <= clear_addr + AW'(1);
    end
  end

  // Scroll copy: read one row down, write the word one row up in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_addr    <= SW'(COLUMNS);
      scroll_wr_pend <= 1'b0;
    end else if (cmd.scroll_start) begin
      scroll_addr    <= SW'(COLUMNS);
      scroll_wr_pend <= 1'b0;
    end else if (cmd.scroll_en) begin
      if (scroll_reading) begin
        scroll_addr    <= scroll_addr + SW'(1);
        scroll_wr_pend <= 1'b1;
      end else begin
        scroll_wr_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scroll_en && scroll_reading) begin
      scroll_wr_addr <= AW'(scroll_addr - SW'(COLUMNS));
    end
  end

  // Range flag of the read in flight.
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_in_range <= read_ok;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.put_en || cmd.read_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_en) begin
      result.cell_value    <= put_cell;
      result.cursor_row    <= RFW'(row_next);
      result.cursor_column <= CFW'(col_next);
      result.scrolled      <= col_last && row_last;
    end else if (cmd.read_load) begin
      result.cell_value    <= rd_in_range ? ram_rd : '0;
      result.cursor_row    <= RFW'(cur_row);
      result.cursor_column <= CFW'(cur_col);
      result.scrolled      <= 1'b0;
    end
  end

  // Status toward the controller.
  assign stat.clear_last   = (clear_addr == AW'(CELLS - 1));
  assign stat.scroll_last  = !scroll_reading;
  assign stat.put_scrolls  = col_last && row_last;
  assign stat.item_is_read = (item.command == txtc_pkg::CMD_READ);
  assign stat.out_busy     = result_valid && result_stall;

  // The linear cursor address tracks row and column.
  a_addr_track: assert property (@(posedge clk) disable iff (rst)
    cur_addr == AW'(cur_row) * AW'(COLUMNS) + AW'(cur_col))
    else $error("cursor address out of step with row and column");

  // Scroll copies never land in the last row.
  a_scroll_dest: assert property (@(posedge clk) disable iff (rst)
    (cmd.scroll_en && scroll_wr_pend) |-> (scroll_wr_addr < LAST_BASE))
    else $error("scroll write into the last row");

  // A result is loaded only into a free result register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.put_en || cmd.read_load) |-> !(result_valid && result_stall))
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

### rtl/txtc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_ctrl: sequencing controller of the text console writer
// Runs the clearing sweep after reset, takes items, waits out reads, and
// holds off items while a scroll copies the rows up.
// ----------------------------------------------------------------------------
module txtc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  output txtc_pkg::cmd_t       cmd,
  input  wire txtc_pkg::stat_t stat
);

  txtc_pkg::state_t state;
  txtc_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= txtc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      txtc_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = txtc_pkg::ST_IDLE;
        end
      end
      txtc_pkg::ST_IDLE: begin
        item_stall = stat.out_busy;
        if (item_valid && !stat.out_busy) begin
          if (stat.item_is_read) begin
            cmd.read_en = 1'b1;
            state_next  = txtc_pkg::ST_READ;
          end else begin
            cmd.put_en = 1'b1;
            if (stat.put_scrolls) begin
              cmd.scroll_start = 1'b1;
              state_next       = txtc_pkg::ST_SCROLL;
            end
          end
        end
      end
      txtc_pkg::ST_READ: begin
        if (!stat.out_busy) begin
          cmd.read_load = 1'b1;
          state_next    = txtc_pkg::ST_IDLE;
        end
      end
      txtc_pkg::ST_SCROLL: begin
        cmd.scroll_en = 1'b1;
        if (stat.scroll_last) begin
          state_next = txtc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = txtc_pkg::ST_CLEAR;
      end
    endcase
  end

  // A put that runs off the last row is followed by the scroll copy.
  a_scroll_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.put_en && stat.put_scrolls) |=> (state == txtc_pkg::ST_SCROLL))
    else $error("scrolling put not followed by the row copy");

  // The read wait state is entered only from an issued read.
  a_read_entry: assert property (@(posedge clk) disable iff (rst)
    ((state == txtc_pkg::ST_READ) && !$past(state == txtc_pkg::ST_READ))
      |-> $past(cmd.read_en))
    else $error("read wait entered without a read");

  // The clearing sweep ends only at its last address.
  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    ($past(state == txtc_pkg::ST_CLEAR) && (state != txtc_pkg::ST_CLEAR))
      |-> $past(stat.clear_last))
    else $error("clearing sweep left early");

endmodule
`default_nettype wire

### rtl/text_console_char_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer_core: text-mode console writer
// Writes attribute/character cells at a cursor over a ROWS x COLUMNS screen
// store, wraps at line ends, scrolls the rows up past the last row, and
// reads back single cells.
//
//   Channel   Handshake                Word
//   item      item_valid / item_stall  item (command, char, read position)
//   result    result_valid / stall     result (cell, cursor, scrolled)
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data (4-bit color)
//
// A put is done as the item is taken; a read waits for the registered RAM read
// and a free result register. A put that scrolls is followed by a copy of
// every row but the top one row up, one RAM read and one write per cell.
// After reset a clearing pass writes zero to all ROWS*COLUMNS cells
// before the first item is taken; configuration writes are taken
// at any time. A put result goes into the result register as the item is
// taken, so a stalled result holds off only the next item.
// ----------------------------------------------------------------------------
module text_console_char_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire txtc_pkg::item_t                  item,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output txtc_pkg::result_t                     result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [txtc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [txtc_pkg::COLOR_W-1:0]     cfg_data
);

  txtc_pkg::cmd_t  cmd;
  txtc_pkg::stat_t stat;

  // Color registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  txtc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  txtc_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text console writer core
// Sends put and read words through the item channel and changes the colors
// between phases. A shadow screen, cursor and color set predict every result
// word, and each received word is compared field by field against the
// oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import txtc_pkg::*;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2100;
  localparam int QUIET_START = 2600;
  localparam int QUIET_END   = 3400;
  localparam int PHASE_WORDS = 180;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [COLOR_W-1:0]     cfg_data     = '0;

  // Shadow of the screen store, cursor and colors.
  logic [CELL_W-1:0]  screen_copy [CELL_COUNT];
  int unsigned        cursor_row_copy = 0;
  int unsigned        cursor_col_copy = 0;
  logic [COLOR_W-1:0] fore_copy = FORE_RESET;
  logic [COLOR_W-1:0] back_copy = BACK_RESET;

  item_t   console_items[$];
  result_t console_results_due[$];
  int      cycle_count  = 0;
  int      quiet_cycles = 0;
  int      fail_count   = 0;

  always #1 clk = ~clk;

  text_console_char_writer_core #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Random idling, switched off during one long window of the run.
  function automatic bit take_break();
    if (cycle_count >= QUIET_START && cycle_count < QUIET_END) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 10;
  endfunction

  // Apply one word to the shadow console and return the result it produces.
  function automatic result_t advance_console(item_t it);
    result_t     r;
    int unsigned idx;
    r = '0;
    if (it.command == CMD_PUT) begin
      r.cell_value = {back_copy, fore_copy, it.char_code};
      screen_copy[cursor_row_copy * SCREEN_COLS + cursor_col_copy] = r.cell_value;
      cursor_col_copy++;
      if (cursor_col_copy >= SCREEN_COLS) begin
        cursor_col_copy = 0;
        cursor_row_copy++;
      end
      // Past the last row everything moves up one row; the last row keeps its cells.
      if (cursor_row_copy >= SCREEN_ROWS) begin
        for (idx = SCREEN_COLS; idx < CELL_COUNT; idx++) begin
          screen_copy[idx - SCREEN_COLS] = screen_copy[idx];
        end
        cursor_row_copy = SCREEN_ROWS - 1;
        cursor_col_copy = 0;
        r.scrolled = 1'b1;
      end
    end else if (it.read_row < SCREEN_ROWS && it.read_column < SCREEN_COLS) begin
      r.cell_value = screen_copy[it.read_row * SCREEN_COLS + it.read_column];
    end
    r.cursor_row    = ROW_FIELD_W'(cursor_row_copy);
    r.cursor_column = COL_FIELD_W'(cursor_col_copy);
    return r;
  endfunction

  // Item driver: predicts each accepted word and presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) begin
        console_results_due.push_back(advance_console(item));
      end
      if (console_items.size() != 0 && !take_break()) begin
        item       <= console_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each accepted word against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (console_results_due.size() == 0) begin
          $error("result word with no prediction waiting: %0h", result);
          fail_count++;
        end else begin
          want = console_results_due.pop_front();
          if (result.cell_value !== want.cell_value) begin
            $error("cell_value expected %0h got %0h", want.cell_value, result.cell_value);
            fail_count++;
          end
          if (result.cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d got %0d", want.cursor_row, result.cursor_row);
            fail_count++;
          end
          if (result.cursor_column !== want.cursor_column) begin
            $error("cursor_column expected %0d got %0d",
                   want.cursor_column, result.cursor_column);
            fail_count++;
          end
          if (result.scrolled !== want.scrolled) begin
            $error("scrolled expected %0b got %0b", want.scrolled, result.scrolled);
            fail_count++;
          end
        end
      end
      result_stall <= take_break();
    end
  end

  // Cycle count and watchdog over cycles in which no word moves.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_put(logic [CHAR_W-1:0] code);
    item_t it;
    it             = '0;
    it.command     = CMD_PUT;
    it.char_code   = code;
    it.read_row    = ROW_FIELD_W'($urandom);
    it.read_column = COL_FIELD_W'($urandom);
    console_items.push_back(it);
  endtask

  task automatic queue_read(logic [ROW_FIELD_W-1:0] row, logic [COL_FIELD_W-1:0] col);
    item_t it;
    it             = '0;
    it.command     = CMD_READ;
    it.char_code   = CHAR_W'($urandom);
    it.read_row    = row;
    it.read_column = col;
    console_items.push_back(it);
  endtask

  // Mostly puts, with reads that now and then fall outside the screen.
  task automatic queue_random(int put_pct);
    if ($urandom_range(0, 99) < put_pct) begin
      queue_put(CHAR_W'($urandom));
    end else if ($urandom_range(0, 99) < 85) begin
      queue_read(ROW_FIELD_W'($urandom_range(0, SCREEN_ROWS - 1)),
                 COL_FIELD_W'($urandom_range(0, SCREEN_COLS - 1)));
    end else begin
      queue_read(ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
    end
  endtask

  task automatic write_color(logic [CFG_INDEX_W-1:0] index, logic [COLOR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_FORE) begin
      fore_copy = value;
    end else begin
      back_copy = value;
    end
  endtask

  // Wait until every queued word is sent and every prediction is met.
  task automatic wait_console_idle();
    do @(negedge clk);
    while (console_items.size() != 0 || item_valid || console_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    for (n = 0; n < CELL_COUNT; n++) begin
      screen_copy[n] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Cleared store, corners, and reads outside the screen.
    queue_read(5'd0, 7'd0);
    queue_read(ROW_FIELD_W'(SCREEN_ROWS - 1), COL_FIELD_W'(SCREEN_COLS - 1));
    queue_read(ROW_FIELD_W'(SCREEN_ROWS), 7'd0);
    queue_read(5'd31, 7'd127);
    queue_read(5'd0, COL_FIELD_W'(SCREEN_COLS));
    // Extreme character codes under the reset colors, read back.
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_read(5'd0, 7'd0);
    queue_read(5'd0, 7'd1);
    wait_console_idle();

    write_color(CFG_FORE, 4'hF);
    write_color(CFG_BACK, 4'hF);
    queue_put(8'hA5);
    queue_read(5'd0, 7'd2);
    wait_console_idle();

    write_color(CFG_FORE, 4'h0);
    write_color(CFG_BACK, 4'h0);
    queue_put(8'h5A);
    queue_read(5'd0, 7'd3);
    queue_read(5'd0, 7'd4);
    wait_console_idle();

    // Random phases; mostly puts that wrap over many lines, with reads between.
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_color(CFG_FORE, 4'h0);
        write_color(CFG_BACK, 4'hF);
      end else if (phase == 1) begin
        write_color(CFG_FORE, 4'hF);
        write_color(CFG_BACK, 4'h0);
      end else begin
        write_color(CFG_FORE, COLOR_W'($urandom));
        write_color(CFG_BACK, COLOR_W'($urandom));
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        queue_random(phase == 7 ? 75 : 92);
      end
      wait_console_idle();
    end

    // Let any scroll copy finish so a stray word would still be seen.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
